>>> design/lidar_point_motion_compensator_assert.svh
// Assertion macros used by the checker file.
`ifndef LIDAR_POINT_MOTION_COMPENSATOR_ASSERT_SVH
`define LIDAR_POINT_MOTION_COMPENSATOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define LPMC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LPMC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/lpmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpmc_pkg
// Types, constants and the CORDIC angle table of the motion compensator.
// ----------------------------------------------------------------------------
package lpmc_pkg;

	localparam int CORDIC_STAGES = 18;
	localparam int CORDIC_RUN    = (CORDIC_STAGES > 30) ? 30 : CORDIC_STAGES;

	localparam logic [31:0]        ANGLE_MAX   = 32'd3373259426;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sh026DD3B6A;

	// register map
	localparam logic [2:0] REG_LATEST_TIME = 3'd0;
	localparam logic [2:0] REG_TIME_SCALE  = 3'd1;
	localparam logic [2:0] REG_ROT_ANGLE   = 3'd2;
	localparam logic [2:0] REG_INV_SIN     = 3'd3;
	localparam logic [2:0] REG_ROT_QUAT    = 3'd4;
	localparam logic [2:0] REG_FRAME_SHIFT = 3'd5;
	localparam logic [2:0] REG_MAX_RANGE   = 3'd6;
	localparam logic [2:0] REG_MODE_FLAGS  = 3'd7;

	// mode_flags bits
	localparam int MODE_ORGANIZED = 0;
	localparam int MODE_ROTATE    = 1;
	localparam int MODE_NEG_C1    = 2;

	typedef struct packed {
		logic signed [31:0] x_pos;
		logic signed [31:0] y_pos;
		logic signed [31:0] z_pos;
		logic               x_is_nan;
		logic [7:0]         intensity;
		logic [63:0]        point_time;
	} pt_t;

	typedef struct packed {
		logic               out_kind;
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic               out_x_is_nan;
		logic [7:0]         out_intensity;
		logic [63:0]        out_time;
	} res_t;

	// point and its time fraction (Q1.30), carried alongside the math
	typedef struct packed {
		pt_t         pt;
		logic [30:0] t;
	} side_t;

	// one CORDIC cell's contents: two sine lanes plus the side data
	typedef struct packed {
		logic signed [33:0] x0;
		logic signed [33:0] y0;
		logic signed [33:0] z0;
		logic signed [33:0] x1;
		logic signed [33:0] y1;
		logic signed [33:0] z1;
		side_t              side;
	} cell_t;

	// atan(2^-i) in Q30, rounded
	function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
		logic signed [33:0] a;
		case (i)
			5'd0:  a = 34'sd843314857;
			5'd1:  a = 34'sd497837829;
			5'd2:  a = 34'sd263043837;
			5'd3:  a = 34'sd133525159;
			5'd4:  a = 34'sd67021687;
			5'd5:  a = 34'sd33543516;
			5'd6:  a = 34'sd16775851;
			5'd7:  a = 34'sd8388437;
			5'd8:  a = 34'sd4194283;
			5'd9:  a = 34'sd2097149;
			5'd10: a = 34'sd1048576;
			5'd11: a = 34'sd524288;
			5'd12: a = 34'sd262144;
			5'd13: a = 34'sd131072;
			5'd14: a = 34'sd65536;
			5'd15: a = 34'sd32768;
			5'd16: a = 34'sd16384;
			5'd17: a = 34'sd8192;
			5'd18: a = 34'sd4096;
			5'd19: a = 34'sd2048;
			5'd20: a = 34'sd1024;
			5'd21: a = 34'sd512;
			5'd22: a = 34'sd256;
			5'd23: a = 34'sd128;
			5'd24: a = 34'sd64;
			5'd25: a = 34'sd32;
			5'd26: a = 34'sd16;
			5'd27: a = 34'sd8;
			5'd28: a = 34'sd4;
			5'd29: a = 34'sd2;
			default: a = 34'sd0;
		endcase
		return a;
	endfunction

endpackage

>>> design/lpmc_cordic_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpmc_cordic_cell
// One CORDIC rotation step for both sine lanes, registered, with side data.
// ----------------------------------------------------------------------------
module lpmc_cordic_cell import lpmc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic [4:0] idx,
	input  logic       in_v,
	input  cell_t      cin,
	output logic       out_v,
	output cell_t      cout
);

	cell_t              nxt;
	logic signed [33:0] ang;
	logic               v_q;
	cell_t              dat_q;

	always_comb begin
		ang = atan_q30(idx);
		nxt = cin;
		if (!cin.z0[33]) begin
			nxt.x0 = cin.x0 - (cin.y0 >>> idx);
			nxt.y0 = cin.y0 + (cin.x0 >>> idx);
			nxt.z0 = cin.z0 - ang;
		end else begin
			nxt.x0 = cin.x0 + (cin.y0 >>> idx);
			nxt.y0 = cin.y0 - (cin.x0 >>> idx);
			nxt.z0 = cin.z0 + ang;
		end
		if (!cin.z1[33]) begin
			nxt.x1 = cin.x1 - (cin.y1 >>> idx);
			nxt.y1 = cin.y1 + (cin.x1 >>> idx);
			nxt.z1 = cin.z1 - ang;
		end else begin
			nxt.x1 = cin.x1 + (cin.y1 >>> idx);
			nxt.y1 = cin.y1 - (cin.x1 >>> idx);
			nxt.z1 = cin.z1 + ang;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dat_q <= nxt;
		end
	end

	assign out_v = v_q;
	assign cout  = dat_q;

endmodule

>>> design/lidar_point_motion_compensator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_point_motion_compensator
// De-skews lidar points: slerp rotation toward the frame pose (rotate mode
// only) plus a scaled shift, range and NaN filtering, fully pipelined.
// ----------------------------------------------------------------------------
//
//  channel | handshake             | payload   | note
//  --------+-----------------------+-----------+------------------------------
//  cfg     | cfg_we                | cfg_data  | cfg_index picks the register
//  point   | pt_valid / pt_stall   | pt        | one point per transaction
//  result  | res_valid / res_stall | res       | zero or one per point
//
//  Throughput is one point per clock while res_stall does not hold it.
//  The pipeline has four stages for the time fraction and slerp angles,
//  one CORDIC cell per stage, seven stages of coefficient, quaternion,
//  matrix and point math, and the result register.
//  The whole pipeline advances together; it holds only while a result sits
//  in the output register with res_stall high, and pt_stall follows that.
//  arst_n clears all valid bits and loads register reset values.
//
module lidar_point_motion_compensator import lpmc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        pt_valid,
	output logic        pt_stall,
	input  pt_t         pt,
	output logic        res_valid,
	input  logic        res_stall,
	output res_t        res
);

	localparam logic signed [64:0] ONE_Q60 = 65'sh01000000000000000;

	// ---------------- configuration registers ----------------
	logic [63:0] latest_time_q;
	logic [47:0] time_scale_q;
	logic [31:0] rot_angle_q;
	logic [31:0] inv_sin_q;
	logic [63:0] rot_quat_q;
	logic [62:0] frame_shift_q;
	logic [31:0] range_lim_q;
	logic [2:0]  mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latest_time_q <= '0;
			time_scale_q  <= '0;
			rot_angle_q   <= '0;
			inv_sin_q     <= '0;
			rot_quat_q    <= '0;
			frame_shift_q <= '0;
			range_lim_q   <= '1;
			mode_q        <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LATEST_TIME: latest_time_q <= cfg_data;
				REG_TIME_SCALE:  time_scale_q  <= cfg_data[47:0];
				REG_ROT_ANGLE:   rot_angle_q   <= cfg_data[31:0];
				REG_INV_SIN:     inv_sin_q     <= cfg_data[31:0];
				REG_ROT_QUAT:    rot_quat_q    <= cfg_data;
				REG_FRAME_SHIFT: frame_shift_q <= cfg_data[62:0];
				REG_MAX_RANGE:   range_lim_q   <= cfg_data[31:0];
				REG_MODE_FLAGS:  mode_q        <= cfg_data[2:0];
				default:         mode_q        <= mode_q;
			endcase
		end
	end

	logic rotate, pass_thru;
	assign rotate    = mode_q[MODE_ROTATE];
	// organized rotate mode: bad points go out unchanged instead of dropped
	assign pass_thru = mode_q[MODE_ROTATE] & mode_q[MODE_ORGANIZED];

	// ---------------- global advance ----------------
	logic res_valid_q;
	logic adv;
	assign adv      = !res_valid_q || !res_stall;
	assign pt_stall = !adv;

	// ---------------- helpers ----------------
	function automatic logic signed [31:0] clamp_q30(input logic signed [51:0] v);
		logic signed [31:0] r;
		if (v > 52'sd1073741824)       r = 32'sd1073741824;
		else if (v < -52'sd1073741824) r = -32'sd1073741824;
		else                           r = v[31:0];
		return r;
	endfunction

	// floor to Q30 and saturate a Q60 matrix term
	function automatic logic signed [31:0] mat_q30(input logic signed [64:0] v);
		logic signed [34:0] s;
		logic signed [31:0] r;
		s = $signed(v[64:30]);
		if (s > 35'sd1073741824)       r = 32'sd1073741824;
		else if (s < -35'sd1073741824) r = -32'sd1073741824;
		else                           r = s[31:0];
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
		logic signed [31:0] r;
		if (v > 37'sd2147483647)       r = 32'sh7FFFFFFF;
		else if (v < -37'sd2147483648) r = 32'sh80000000;
		else                           r = v[31:0];
		return r;
	endfunction

	// ---------------- s1: elapsed time ----------------
	logic        v_s1;
	pt_t         pt_s1;
	logic [47:0] d_s1;
	logic        dbig_s1;
	logic [63:0] d_full;
	logic        late;

	assign late   = pt.point_time > latest_time_q;
	assign d_full = latest_time_q - pt.point_time;

	// ---------------- s2: partial products of d * time_scale ----------------
	logic        v_s2;
	pt_t         pt_s2;
	logic [47:0] hl_s2, lh_s2, ll_s2;
	logic        hhnz_s2, big_s2;
	logic [47:0] hl, lh, ll;

	assign hl = d_s1[47:24] * time_scale_q[23:0];
	assign lh = d_s1[23:0] * time_scale_q[47:24];
	assign ll = d_s1[23:0] * time_scale_q[23:0];

	// ---------------- s3: fraction t, Q1.30, clamped to 1.0 ----------------
	logic        v_s3;
	pt_t         pt_s3;
	logic [30:0] t_s3;
	logic [48:0] mid, prod;
	logic        over;

	assign mid  = {1'b0, hl_s2} + {1'b0, lh_s2};
	assign prod = {1'b0, mid[23:0], 24'd0} + {1'b0, ll_s2};
	assign over = big_s2 | hhnz_s2 | (mid[48:24] != 25'd0) | prod[48];

	// ---------------- s4: second slerp angle ----------------
	logic        v_s4;
	pt_t         pt_s4;
	logic [30:0] t_s4;
	logic [31:0] a1_s4;
	logic [31:0] th;
	logic [62:0] tprod;
	logic [31:0] a0;

	assign th    = (rot_angle_q > ANGLE_MAX) ? ANGLE_MAX : rot_angle_q;
	assign tprod = {32'd0, t_s3} * {31'd0, th};
	assign a0    = th - a1_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pt_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pt_s1   <= pt;
			d_s1    <= late ? 48'd0 : d_full[47:0];
			dbig_s1 <= !late && (d_full[63:48] != 16'd0);

			pt_s2   <= pt_s1;
			hl_s2   <= hl;
			lh_s2   <= lh;
			ll_s2   <= ll;
			hhnz_s2 <= (d_s1[47:24] != 24'd0) && (time_scale_q[47:24] != 24'd0);
			big_s2  <= dbig_s1 && (time_scale_q != 48'd0);

			pt_s3   <= pt_s2;
			t_s3    <= over ? 31'h40000000 : {1'b0, prod[47:18]};

			pt_s4   <= pt_s3;
			t_s4    <= t_s3;
			a1_s4   <= tprod[61:30];
		end
	end

	// ---------------- CORDIC chain: sin(a0) and sin(a1) ----------------
	cell_t                chain [CORDIC_RUN+1];
	logic [CORDIC_RUN:0]  chain_v;

	always_comb begin
		chain[0].x0        = CORDIC_GAIN;
		chain[0].y0        = '0;
		chain[0].z0        = $signed({3'd0, a0[31:1]});
		chain[0].x1        = CORDIC_GAIN;
		chain[0].y1        = '0;
		chain[0].z1        = $signed({3'd0, a1_s4[31:1]});
		chain[0].side.pt   = pt_s4;
		chain[0].side.t    = t_s4;
	end
	assign chain_v[0] = v_s4;

	for (genvar g = 0; g < CORDIC_RUN; g++) begin : g_cell
		lpmc_cordic_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (adv),
			.idx   (5'(g)),
			.in_v  (chain_v[g]),
			.cin   (chain[g]),
			.out_v (chain_v[g+1]),
			.cout  (chain[g+1])
		);
	end

	cell_t cend;
	assign cend = chain[CORDIC_RUN];

	// ---------------- s6: slerp coefficients ----------------
	logic               v_s6;
	side_t              sd_s6;
	logic signed [49:0] c0_s6, c1_s6;
	logic signed [66:0] m0p, m1p;

	assign m0p = cend.y0 * $signed({1'b0, inv_sin_q});
	assign m1p = cend.y1 * $signed({1'b0, inv_sin_q});

	// ---------------- s7: c1 times quaternion ----------------
	logic               v_s7;
	side_t              sd_s7;
	logic signed [49:0] c0_s7;
	logic signed [65:0] pq_s7 [4];
	logic signed [49:0] c1n;
	logic signed [65:0] pq [4];

	assign c1n = mode_q[MODE_NEG_C1] ? -c1_s6 : c1_s6;
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			pq[k] = c1n * $signed(rot_quat_q[16*k +: 16]);
		end
	end

	// ---------------- s8: slerp quaternion, Q30 ----------------
	logic               v_s8;
	side_t              sd_s8;
	logic signed [31:0] q_s8 [4];
	logic signed [51:0] qsum [4];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			qsum[k] = $signed(pq_s7[k][65:15]);
		end
		qsum[0] = qsum[0] + c0_s7;
	end

	// ---------------- s9: quaternion products ----------------
	logic               v_s9;
	side_t              sd_s9;
	logic signed [63:0] xx_s9, yy_s9, zz_s9, xy_s9, xz_s9, yz_s9, wx_s9, wy_s9, wz_s9;

	// ---------------- s10: rotation matrix ----------------
	logic               v_s10;
	side_t              sd_s10;
	logic signed [31:0] m_s10 [9];
	logic signed [64:0] dxx, dyy, dzz, dxy, dxz, dyz, dwx, dwy, dwz;

	assign dxx = $signed({xx_s9, 1'b0});
	assign dyy = $signed({yy_s9, 1'b0});
	assign dzz = $signed({zz_s9, 1'b0});
	assign dxy = $signed({xy_s9, 1'b0});
	assign dxz = $signed({xz_s9, 1'b0});
	assign dyz = $signed({yz_s9, 1'b0});
	assign dwx = $signed({wx_s9, 1'b0});
	assign dwy = $signed({wy_s9, 1'b0});
	assign dwz = $signed({wz_s9, 1'b0});

	// ---------------- s11: matrix times point, shift times t ----------------
	logic               v_s11;
	side_t              sd_s11;
	logic signed [63:0] mp_s11 [9];
	logic signed [52:0] op_s11 [3];
	logic signed [31:0] pc [3];

	assign pc[0] = sd_s10.pt.x_pos;
	assign pc[1] = sd_s10.pt.y_pos;
	assign pc[2] = sd_s10.pt.z_pos;

	// ---------------- s12: row sums and offsets ----------------
	logic               v_s12;
	side_t              sd_s12;
	logic signed [35:0] r_s12 [3];
	logic signed [26:0] off_s12 [3];
	logic signed [65:0] rsum [3];
	logic signed [31:0] pr [3];

	assign pr[0] = sd_s11.pt.x_pos;
	assign pr[1] = sd_s11.pt.y_pos;
	assign pr[2] = sd_s11.pt.z_pos;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			rsum[k] = mp_s11[3*k] + mp_s11[3*k+1] + mp_s11[3*k+2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
		end else if (adv) begin
			v_s6  <= chain_v[CORDIC_RUN];
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s6 <= cend.side;
			c0_s6 <= m0p[65:16];
			c1_s6 <= m1p[65:16];

			sd_s7 <= sd_s6;
			c0_s7 <= c0_s6;
			for (int k = 0; k < 4; k++) begin
				pq_s7[k] <= pq[k];
			end

			sd_s8 <= sd_s7;
			for (int k = 0; k < 4; k++) begin
				q_s8[k] <= clamp_q30(qsum[k]);
			end

			// q_s8 order: w, x, y, z
			sd_s9 <= sd_s8;
			xx_s9 <= q_s8[1] * q_s8[1];
			yy_s9 <= q_s8[2] * q_s8[2];
			zz_s9 <= q_s8[3] * q_s8[3];
			xy_s9 <= q_s8[1] * q_s8[2];
			xz_s9 <= q_s8[1] * q_s8[3];
			yz_s9 <= q_s8[2] * q_s8[3];
			wx_s9 <= q_s8[0] * q_s8[1];
			wy_s9 <= q_s8[0] * q_s8[2];
			wz_s9 <= q_s8[0] * q_s8[3];

			sd_s10   <= sd_s9;
			m_s10[0] <= mat_q30(ONE_Q60 - (dyy + dzz));
			m_s10[1] <= mat_q30(dxy - dwz);
			m_s10[2] <= mat_q30(dxz + dwy);
			m_s10[3] <= mat_q30(dxy + dwz);
			m_s10[4] <= mat_q30(ONE_Q60 - (dxx + dzz));
			m_s10[5] <= mat_q30(dyz - dwx);
			m_s10[6] <= mat_q30(dxz - dwy);
			m_s10[7] <= mat_q30(dyz + dwx);
			m_s10[8] <= mat_q30(ONE_Q60 - (dxx + dyy));

			sd_s11 <= sd_s10;
			for (int k = 0; k < 9; k++) begin
				mp_s11[k] <= m_s10[k] * pc[k % 3];
			end
			for (int k = 0; k < 3; k++) begin
				op_s11[k] <= $signed({1'b0, sd_s10.t}) *
					$signed(frame_shift_q[21*k +: 21]);
			end

			sd_s12 <= sd_s11;
			for (int k = 0; k < 3; k++) begin
				r_s12[k]   <= rotate ? $signed(rsum[k][65:30]) : 36'(pr[k]);
				off_s12[k] <= $signed(op_s11[k][52:26]);
			end
		end
	end

	// ---------------- output: offset, range check, select ----------------
	logic signed [36:0] rr [3];
	logic signed [36:0] mag [3];
	logic               oor;
	logic               nan_pt;
	logic               emit;
	res_t               res_d;
	res_t               res_q;

	always_comb begin
		oor = 1'b0;
		for (int k = 0; k < 3; k++) begin
			rr[k]  = r_s12[k] + off_s12[k];
			mag[k] = rr[k][36] ? -rr[k] : rr[k];
			if (mag[k] > $signed({5'd0, range_lim_q})) oor = 1'b1;
		end
		nan_pt = sd_s12.pt.x_is_nan;
		emit   = (nan_pt || oor) ? pass_thru : 1'b1;

		res_d.out_intensity = sd_s12.pt.intensity;
		res_d.out_time      = sd_s12.pt.point_time;
		if (nan_pt || oor) begin
			// original point, untouched
			res_d.out_kind     = 1'b1;
			res_d.out_x        = sd_s12.pt.x_pos;
			res_d.out_y        = sd_s12.pt.y_pos;
			res_d.out_z        = sd_s12.pt.z_pos;
			res_d.out_x_is_nan = sd_s12.pt.x_is_nan;
		end else begin
			res_d.out_kind     = 1'b0;
			res_d.out_x        = sat32(rr[0]);
			res_d.out_y        = sat32(rr[1]);
			res_d.out_z        = sat32(rr[2]);
			res_d.out_x_is_nan = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= v_s12 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

>>> design/lpmc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpmc_checker
// Port-level checks on the motion compensator, bound to the top level.
// ----------------------------------------------------------------------------
`include "lidar_point_motion_compensator_assert.svh"

module lpmc_checker import lpmc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic pt_stall,
	input logic res_valid,
	input logic res_stall,
	input res_t res
);

	`LPMC_ASSERT_NXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res), "stalled result changed")
	`LPMC_ASSERT_IMP(a_stall_cause, pt_stall, res_valid && res_stall, "input stalled without output backpressure")
	`LPMC_ASSERT_IMP(a_nan_kind, res_valid && res.out_x_is_nan, res.out_kind, "NaN mark on compensated point")

endmodule

bind lidar_point_motion_compensator lpmc_checker u_lpmc_checker (.*);

>>> sim/lpmc_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpmc_scoreboard
// Watches the register port and both point channels of the motion
// compensator. It predicts each compensated point, queues the expected
// results and compares every result transaction field by field.
// ----------------------------------------------------------------------------
module lpmc_scoreboard import lpmc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        pt_valid,
	input  logic        pt_stall,
	input  pt_t         pt,
	input  logic        res_valid,
	input  logic        res_stall,
	input  res_t        res,
	output int          mismatches,
	output int          outstanding
);

	localparam longint ONE_Q30 = 64'sd1 << 30;

	// atan(2^-i), Q30
	localparam longint ATAN_TBL [30] = '{
		843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
		16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
		65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
		16, 8, 4, 2
	};

	logic [63:0] latest_time;
	logic [47:0] time_scale;
	logic [31:0] rot_angle;
	logic [31:0] inv_sin_angle;
	logic [63:0] rot_quat;
	logic [62:0] frame_shift;
	logic [31:0] range_lim;
	logic [2:0]  mode_flags;

	res_t compensated_q [$];
	int   err_cnt;

	assign mismatches  = err_cnt;
	assign outstanding = compensated_q.size();

	function automatic longint clip(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// time fraction, unsigned Q1.30
	function automatic longint time_fraction(logic [63:0] stamp);
		logic [63:0]  d;
		logic [111:0] prod;
		d = (stamp > latest_time) ? 64'd0 : latest_time - stamp;
		prod = d * time_scale;
		if (prod >= (112'd1 << 48))
			return ONE_Q30;
		return longint'(prod[47:18]);
	endfunction

	function automatic longint sine_q30(longint ang);
		longint cx, cy, nx;
		cx = longint'(CORDIC_GAIN);
		cy = 0;
		for (int i = 0; i < CORDIC_RUN; i++) begin
			if (ang >= 0) begin
				nx = cx - (cy >>> i);
				cy = cy + (cx >>> i);
				ang -= ATAN_TBL[i];
			end else begin
				nx = cx + (cy >>> i);
				cy = cy - (cx >>> i);
				ang += ATAN_TBL[i];
			end
			cx = nx;
		end
		return cy;
	endfunction

	function automatic longint mat_q30(longint v60);
		return clip(v60 >>> 30, -ONE_Q30, ONE_Q30);
	endfunction

	// returns 1 when the point yields a result transaction
	function automatic bit compensate(input pt_t p, output res_t r);
		longint          t, c0, c1, inv, off;
		longint unsigned th, a1, a0;
		longint          q [4];
		longint          m [9];
		longint          pos [3];
		longint          rr [3];
		longint          tx, ty, tz, twx, twy, twz, txx, txy, txz, tyy, tyz, tzz;
		bit              rotate, pass;
		rotate = mode_flags[MODE_ROTATE];
		pass   = rotate && mode_flags[MODE_ORGANIZED];
		r.out_kind      = 1'b1;
		r.out_x         = p.x_pos;
		r.out_y         = p.y_pos;
		r.out_z         = p.z_pos;
		r.out_x_is_nan  = p.x_is_nan;
		r.out_intensity = p.intensity;
		r.out_time      = p.point_time;
		if (p.x_is_nan)
			return pass;
		pos[0] = p.x_pos;
		pos[1] = p.y_pos;
		pos[2] = p.z_pos;
		t = time_fraction(p.point_time);
		if (rotate) begin
			th  = (rot_angle > ANGLE_MAX) ? ANGLE_MAX : rot_angle;
			a1  = (longint'(t) * th) >> 30;
			a0  = th - a1;
			inv = longint'({32'd0, inv_sin_angle});
			c0  = (sine_q30(longint'(a0 >> 1)) * inv) >>> 16;
			c1  = (sine_q30(longint'(a1 >> 1)) * inv) >>> 16;
			if (mode_flags[MODE_NEG_C1])
				c1 = -c1;
			for (int k = 0; k < 4; k++)
				q[k] = (c1 * longint'($signed(rot_quat[16*k +: 16]))) >>> 15;
			q[0] += c0;
			for (int k = 0; k < 4; k++)
				q[k] = clip(q[k], -ONE_Q30, ONE_Q30);
			tx = 2 * q[1]; ty = 2 * q[2]; tz = 2 * q[3];
			twx = tx * q[0]; twy = ty * q[0]; twz = tz * q[0];
			txx = tx * q[1]; txy = ty * q[1]; txz = tz * q[1];
			tyy = ty * q[2]; tyz = tz * q[2]; tzz = tz * q[3];
			m[0] = mat_q30((64'sd1 << 60) - (tyy + tzz));
			m[1] = mat_q30(txy - twz);
			m[2] = mat_q30(txz + twy);
			m[3] = mat_q30(txy + twz);
			m[4] = mat_q30((64'sd1 << 60) - (txx + tzz));
			m[5] = mat_q30(tyz - twx);
			m[6] = mat_q30(txz - twy);
			m[7] = mat_q30(tyz + twx);
			m[8] = mat_q30((64'sd1 << 60) - (txx + tyy));
			for (int k = 0; k < 3; k++)
				rr[k] = (m[3*k] * pos[0] + m[3*k+1] * pos[1] + m[3*k+2] * pos[2]) >>> 30;
		end else begin
			for (int k = 0; k < 3; k++)
				rr[k] = pos[k];
		end
		for (int k = 0; k < 3; k++) begin
			off = (t * longint'($signed(frame_shift[21*k +: 21]))) >>> 26;
			rr[k] += off;
			if (((rr[k] < 0) ? -rr[k] : rr[k]) > longint'({32'd0, range_lim}))
				return pass;
		end
		r.out_kind     = 1'b0;
		r.out_x        = 32'(clip(rr[0], -64'sd2147483648, 64'sd2147483647));
		r.out_y        = 32'(clip(rr[1], -64'sd2147483648, 64'sd2147483647));
		r.out_z        = 32'(clip(rr[2], -64'sd2147483648, 64'sd2147483647));
		r.out_x_is_nan = 1'b0;
		return 1'b1;
	endfunction

	task automatic report(string field, logic [63:0] got, logic [63:0] want);
		$display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
		err_cnt++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t exp_res;
		if (!arst_n) begin
			latest_time   <= '0;
			time_scale    <= '0;
			rot_angle     <= '0;
			inv_sin_angle <= '0;
			rot_quat      <= '0;
			frame_shift   <= '0;
			range_lim     <= '1;
			mode_flags    <= '0;
			err_cnt       = 0;
			compensated_q.delete();
		end else begin
			if (pt_valid && !pt_stall) begin
				if (compensate(pt, exp_res))
					compensated_q.push_back(exp_res);
			end
			if (res_valid && !res_stall) begin
				if (compensated_q.size() == 0) begin
					report("unexpected transaction", res.out_time, '0);
				end else begin
					exp_res = compensated_q.pop_front();
					if (res.out_kind != exp_res.out_kind)
						report("out_kind", res.out_kind, exp_res.out_kind);
					if (res.out_x != exp_res.out_x)
						report("out_x", res.out_x, exp_res.out_x);
					if (res.out_y != exp_res.out_y)
						report("out_y", res.out_y, exp_res.out_y);
					if (res.out_z != exp_res.out_z)
						report("out_z", res.out_z, exp_res.out_z);
					if (res.out_x_is_nan != exp_res.out_x_is_nan)
						report("out_x_is_nan", res.out_x_is_nan, exp_res.out_x_is_nan);
					if (res.out_intensity != exp_res.out_intensity)
						report("out_intensity", res.out_intensity, exp_res.out_intensity);
					if (res.out_time != exp_res.out_time)
						report("out_time", res.out_time, exp_res.out_time);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_LATEST_TIME: latest_time   <= cfg_data;
					REG_TIME_SCALE:  time_scale    <= cfg_data[47:0];
					REG_ROT_ANGLE:   rot_angle     <= cfg_data[31:0];
					REG_INV_SIN:     inv_sin_angle <= cfg_data[31:0];
					REG_ROT_QUAT:    rot_quat      <= cfg_data;
					REG_FRAME_SHIFT: frame_shift   <= cfg_data[62:0];
					REG_MAX_RANGE:   range_lim     <= cfg_data[31:0];
					REG_MODE_FLAGS:  mode_flags    <= cfg_data[2:0];
					default: ;
				endcase
			end
		end
	end

endmodule

>>> sim/lidar_point_motion_compensator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_point_motion_compensator_tb
// Drives directed and random lidar points through the motion compensator
// under a series of frame settings, with random idling on both channels and
// one long output hold-off. The scoreboard predicts and checks each result.
// ----------------------------------------------------------------------------
module lidar_point_motion_compensator_tb;
	import lpmc_pkg::*;

	localparam int DRAIN_CYCLES = CORDIC_RUN + 20; // pipeline depth plus margin
	localparam int WATCHDOG_MAX = 20000;            // cycles with no transaction
	localparam int RAND_PHASES  = 10;
	localparam int PHASE_POINTS = 105;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;
	logic        pt_valid;
	logic        pt_stall;
	pt_t         pt;
	logic        res_valid;
	logic        res_stall;
	res_t        res;
	int          mismatches;
	int          outstanding;

	// receiver hold-off request, raised once by the stimulus
	bit          hold_req;
	int          idle_cycles;

	// frame settings currently loaded, kept for shaping timestamps
	logic [63:0] frame_latest;
	logic [31:0] frame_span;

	lidar_point_motion_compensator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pt_valid  (pt_valid),
		.pt_stall  (pt_stall),
		.pt        (pt),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	lpmc_scoreboard u_scoreboard (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pt_valid    (pt_valid),
		.pt_stall    (pt_stall),
		.pt          (pt),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.res         (res),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// mostly back to back, some short gaps, a few long ones
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	// one point transaction; a zero gap keeps valid high across items
	task automatic send_point(pt_t p);
		int g;
		g = gap_len();
		if (g > 0) begin
			pt_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		pt_valid <= 1'b1;
		pt       <= p;
		do @(posedge clk); while (pt_stall);
	endtask

	// loads all registers back to back, one write per edge
	task automatic load_frame(logic [63:0] regs [8]);
		for (int i = 0; i < 8; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data  <= regs[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		frame_latest = regs[REG_LATEST_TIME];
		@(posedge clk);
	endtask

	// block goes idle: all results back, then dropped points flushed out
	task automatic drain();
		pt_valid <= 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic signed [31:0] rand_coord();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return $signed(32'($urandom_range(0, 32'h00FF_FFFF))) - 32'sh0080_0000;
		if (r < 9)
			return $signed(32'($urandom_range(0, 32'h0FFF_FFFF))) - 32'sh0800_0000;
		return $urandom;
	endfunction

	function automatic pt_t rand_point();
		pt_t p;
		int  r;
		p.x_pos     = rand_coord();
		p.y_pos     = rand_coord();
		p.z_pos     = rand_coord();
		p.x_is_nan  = ($urandom_range(0, 9) == 0);
		p.intensity = $urandom;
		r = $urandom_range(0, 19);
		if (r < 16)
			p.point_time = frame_latest - $urandom_range(0, frame_span);
		else if (r < 18)
			p.point_time = frame_latest + $urandom_range(1, 1000);
		else
			p.point_time = {$urandom, $urandom};
		return p;
	endfunction

	// random frame, with extremes mixed in
	task automatic random_frame();
		logic [63:0] regs [8];
		real         theta;
		real         s;
		int          r;
		frame_span = $urandom_range(1000, 2000000);
		regs[REG_LATEST_TIME] = {$urandom, $urandom};
		r = $urandom_range(0, 9);
		if (r == 0)
			regs[REG_TIME_SCALE] = 64'hFFFF_FFFF_FFFF;
		else if (r == 1)
			regs[REG_TIME_SCALE] = 64'd0;
		else
			regs[REG_TIME_SCALE] = (64'd1 << 48) / frame_span;
		r = $urandom_range(0, 9);
		if (r == 0)
			regs[REG_ROT_ANGLE] = 64'(ANGLE_MAX);
		else if (r == 1)
			regs[REG_ROT_ANGLE] = 64'hFFFF_FFFF;
		else
			regs[REG_ROT_ANGLE] = $urandom_range(1000, 400000000);
		theta = real'(regs[REG_ROT_ANGLE] > ANGLE_MAX ? ANGLE_MAX : regs[REG_ROT_ANGLE])
			/ 2147483648.0;
		s = $sin(theta);
		if ($urandom_range(0, 7) == 0 || s < 1.0e-4)
			regs[REG_INV_SIN] = $urandom;
		else
			regs[REG_INV_SIN] = 64'(longint'(65536.0 / s));
		regs[REG_ROT_QUAT] = {$urandom, $urandom};
		regs[REG_FRAME_SHIFT] = {$urandom, $urandom} & 64'h7FFF_FFFF_FFFF_FFFF;
		r = $urandom_range(0, 9);
		if (r == 0)
			regs[REG_MAX_RANGE] = 64'd0;
		else if (r < 4)
			regs[REG_MAX_RANGE] = 64'hFFFF_FFFF;
		else
			regs[REG_MAX_RANGE] = $urandom_range(32'h0010_0000, 32'h7FFF_FFFF);
		regs[REG_MODE_FLAGS] = $urandom_range(0, 7);
		load_frame(regs);
	endtask

	// extremes of every field, NaN, timestamps at and past the frame end
	task automatic directed_points();
		pt_t p;
		for (int i = 0; i < 12; i++) begin
			p.x_pos      = (i % 3 == 0) ? 32'sh7FFF_FFFF : ((i % 3 == 1) ? 32'sh8000_0000 : 0);
			p.y_pos      = (i % 4 == 0) ? 32'sh8000_0000 : 32'sh0001_0000 * i;
			p.z_pos      = (i % 2 == 0) ? -32'sh0002_0000 : 32'sh7FFF_FFFF;
			p.x_is_nan   = (i == 3 || i == 8);
			p.intensity  = (i % 2 == 0) ? 8'd0 : 8'hFF;
			case (i % 4)
				0: p.point_time = 64'd0;
				1: p.point_time = 64'hFFFF_FFFF_FFFF_FFFF;
				2: p.point_time = frame_latest;
				default: p.point_time = frame_latest - 64'd777;
			endcase
			if (i >= 9) begin
				p.x_pos = 32'sh0010_0000;
				p.y_pos = -32'sh0003_0000;
				p.z_pos = 32'sh0000_8000;
			end
			send_point(p);
		end
	endtask

	// receiver: random stalls, free-running stretches, and one long hold-off
	initial begin
		int r;
		bit held;
		held = 1'b0;
		res_stall <= 1'b1;
		@(posedge arst_n);
		forever begin
			if (hold_req && !held) begin
				res_stall <= 1'b1;
				repeat (400) @(posedge clk);
				held = 1'b1;
			end
			r = $urandom_range(0, 99);
			if (r < 60) begin
				res_stall <= 1'b0;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end else if (r < 92) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end else begin
				res_stall <= 1'b1;
				repeat ($urandom_range(10, 40)) @(posedge clk);
			end
		end
	end

	// watchdog on transaction activity
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((pt_valid && !pt_stall) || (res_valid && !res_stall) || cfg_we)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_MAX) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		logic [63:0] regs [8];
		arst_n     <= 1'b0;
		cfg_we     <= 1'b0;
		cfg_index  <= '0;
		cfg_data   <= '0;
		pt_valid   <= 1'b0;
		pt         <= '0;
		hold_req   = 1'b0;
		frame_latest = '0;
		frame_span   = 1000;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: translate-only, t stays zero
		directed_points();
		drain();

		// translate-only with a live fraction and a tight range limit
		frame_span = 100000;
		regs = '{64'd5_000_000, (64'd1 << 48) / 100000, 64'd0, 64'd0, 64'd0,
			64'h7FFF_FFFF_FFFF_FFFF, 64'h0100_0000, 64'd1};
		load_frame(regs);
		directed_points();
		drain();

		// organized rotate with negated second coefficient
		regs = '{64'd5_000_000, (64'd1 << 48) / 100000, 64'(ANGLE_MAX), 64'h0001_0000,
			64'h8000_7FFF_1234_4000, 64'h0010_0000_0010_0000, 64'h0100_0000, 64'd7};
		load_frame(regs);
		directed_points();
		drain();

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			random_frame();
			for (int n = 0; n < PHASE_POINTS; n++) begin
				if (ph == 3 && n == 10)
					hold_req = 1'b1;
				send_point(rand_point());
			end
			drain();
		end

		if (mismatches == 0 && outstanding == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
